### rtl/core/icla_pkg.sv
// Shared types and constants for the idle counter load averager.
`default_nettype none

package icla_pkg;

    localparam int WINDOW_DEPTH = 5;
    localparam int LOAD_FULL    = 100;
    localparam int QUOT_W       = 7;
    localparam int DIVD_W       = 39;
    localparam int QUEUE_DEPTH  = 2;
    localparam int WIN_IDX_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W        = $clog2(LOAD_FULL * WINDOW_DEPTH + 1);

    // Mean by reciprocal multiply; exact for ring sums up to 16 * LOAD_FULL.
    localparam int AVG_SHIFT  = 16;
    localparam int AVG_RECIP  = ((1 << AVG_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam int AVG_PROD_W = SUM_W + AVG_SHIFT + 1;

    localparam logic [7:0]           ERR_MARK = 8'hFF;
    localparam logic [WIN_IDX_W-1:0] WIN_LAST = WIN_IDX_W'(WINDOW_DEPTH - 1);

    typedef struct packed {
        logic [63:0] timer_now;
        logic [63:0] idle_count;
        logic        sample_valid;
    } t_in;

    typedef struct packed {
        logic [6:0] sample_load;
        logic [6:0] average_load;
        logic       window_error;
    } t_out;

    // Classified sample handed from the front end to the back end.
    typedef struct packed {
        logic        sample_valid;
        logic        zero_load;
        logic [31:0] dt;
        logic [31:0] di;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LDIV,
        ST_SUM,
        ST_AVG,
        ST_OUT
    } t_back_state;

endpackage

`default_nettype wire

### rtl/core/icla_front.sv
// Front end: takes samples, forms the 32-bit deltas and flags trivial loads.
`default_nettype none

module icla_front
    import icla_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_in  i_data,
    input  wire logic i_full,
    output logic      o_stall,
    output logic      o_push,
    output t_job      o_job
);

    logic [63:0] r_last_ts;
    logic [31:0] r_last_idle;
    logic [31:0] dt;
    logic [31:0] di;

    assign dt      = i_data.timer_now[31:0] - r_last_ts[31:0];
    assign di      = i_data.idle_count[31:0] - r_last_idle;
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_job.sample_valid = i_data.sample_valid;
        // Load is zero on first sample, zero time delta, or idle at or above time.
        o_job.zero_load    = (r_last_ts == 64'd0) || (dt == 32'd0) || (di >= dt);
        o_job.dt           = dt;
        o_job.di           = di;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ts   <= 64'd0;
            r_last_idle <= 32'd0;
        end else if (o_push && i_data.sample_valid) begin
            r_last_ts   <= i_data.timer_now;
            r_last_idle <= i_data.idle_count[31:0];
        end
    end

endmodule

`default_nettype wire

### rtl/core/icla_fifo.sv
// Two-entry queue between the front and back ends.
`default_nettype none

module icla_fifo
    import icla_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/icla_div.sv
// Restoring divider, one quotient bit per cycle, for quotients below 2**QUOT_W.
`default_nettype none

module icla_div
    import icla_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [31:0]       i_divisor,
    output logic                   o_done,
    output logic [QUOT_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic [DIVD_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_den;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              ge;

    assign ge     = (r_rem >= r_den);
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_den  <= DIVD_W'({i_divisor, {(QUOT_W - 1){1'b0}}});
            r_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_den;
            end
            r_quot <= {r_quot[QUOT_W-2:0], ge};
            r_den  <= r_den >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUOT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/icla_back.sv
// Back end: load division, ring update, ring sum and mean, result register.
`default_nettype none

module icla_back
    import icla_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);

    t_back_state          r_state;
    t_back_state          n_state;
    logic [7:0]           r_win [WINDOW_DEPTH];
    logic [WIN_IDX_W-1:0] r_slot;
    logic [WIN_IDX_W-1:0] r_idx;
    logic [SUM_W-1:0]     r_sum;
    logic                 r_err;
    logic [6:0]           r_load;
    logic [6:0]           r_avg;
    logic                 div_start;
    logic [DIVD_W-1:0]    div_dividend;
    logic [31:0]          div_divisor;
    logic                 div_done;
    logic [QUOT_W-1:0]    div_quot;
    logic                 wr_en;
    logic [7:0]           wr_val;
    logic [DIVD_W-1:0]    prod;
    logic [6:0]           ldiv_load;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [6:0]           avg_quot;

    // di * 100 as shifted adds
    assign prod = DIVD_W'({i_job.di, 6'b0}) + DIVD_W'({i_job.di, 5'b0})
                + DIVD_W'({i_job.di, 2'b0});
    assign ldiv_load = 7'(LOAD_FULL) - div_quot;

    // floor(sum / WINDOW_DEPTH) by reciprocal multiply
    assign avg_prod = AVG_PROD_W'(r_sum) * AVG_PROD_W'(AVG_RECIP);
    assign avg_quot = avg_prod[AVG_SHIFT +: 7];

    icla_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = prod;
        div_divisor  = i_job.dt;
        wr_en        = 1'b0;
        wr_val       = 8'd0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (!i_job.sample_valid) begin
                        wr_en   = 1'b1;
                        wr_val  = ERR_MARK;
                        n_state = ST_SUM;
                    end else if (i_job.zero_load) begin
                        wr_en   = 1'b1;
                        n_state = ST_SUM;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_LDIV;
                    end
                end
            end
            ST_LDIV: begin
                if (div_done) begin
                    wr_en   = 1'b1;
                    wr_val  = {1'b0, ldiv_load};
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_idx == WIN_LAST) begin
                    n_state = ST_AVG;
                end
            end
            ST_AVG: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_win[i] <= 8'd0;
            end
            r_slot <= '0;
        end else if (wr_en) begin
            r_win[r_slot] <= wr_val;
            r_slot        <= (r_slot == WIN_LAST) ? '0 : r_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_load <= wr_val[6:0] & {7{wr_val != ERR_MARK}};
            r_idx  <= '0;
            r_sum  <= '0;
            r_err  <= 1'b0;
        end
        if (r_state == ST_SUM) begin
            if (r_win[r_idx] == ERR_MARK) begin
                r_err <= 1'b1;
            end else begin
                r_sum <= r_sum + SUM_W'(r_win[r_idx]);
            end
            r_idx <= r_idx + 1'b1;
        end
        if (r_state == ST_AVG) begin
            r_avg <= r_err ? 7'd0 : avg_quot;
        end
    end

    assign o_valid = (r_state == ST_OUT);

    always_comb begin
        o_data.sample_load  = r_load;
        o_data.average_load = r_avg;
        o_data.window_error = r_err;
    end

endmodule

`default_nettype wire

### rtl/core/idle_counter_load_averager_unit.sv
// Top level of the idle counter load averager.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------
//  input   | in        | i_valid / o_stall  | i_data (t_in)
//  result  | out       | o_valid / i_stall  | o_data (t_out)
//
// In the back end a sample passes through a queue pop, the load division (seven
// quotient steps and a done strobe), the ring sum at one ring entry per cycle,
// the mean and the result state. A zero or error load skips the division.
// Reset clears the saved timestamp, idle count, ring and slot.
// The two-entry queue keeps taking samples, until it is full, while a result waits on i_stall.
`default_nettype none

module idle_counter_load_averager_unit
    import icla_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);

    logic q_push;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_job front_job;
    t_job back_job;

    icla_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_full  (q_full),
        .o_stall (o_stall),
        .o_push  (q_push),
        .o_job   (front_job)
    );

    icla_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (back_job)
    );

    icla_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_job   (back_job),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

`ifndef ASSERT_OFF
    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.average_load <= 7'(LOAD_FULL))
        else $error("average load out of range");

    a_load_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.sample_load <= 7'(LOAD_FULL))
        else $error("sample load out of range");

    a_err_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.window_error) |-> o_data.average_load == 7'd0)
        else $error("average not zero with error in window");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire
